// ===== sv/fdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Follower drive decision package
// Shared types, register indexes, reset values and output codes.
// ----------------------------------------------------------------------------
package fdd_pkg;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_CRASH_LIMIT  = 3'd0;
  localparam cfg_idx_t REG_LINK_TIMEOUT = 3'd1;
  localparam cfg_idx_t REG_SLOW_LEVEL   = 3'd2;
  localparam cfg_idx_t REG_MEDIUM_LEVEL = 3'd3;
  localparam cfg_idx_t REG_FAST_LEVEL   = 3'd4;
  localparam cfg_idx_t REG_BEEP_SHORT   = 3'd5;
  localparam cfg_idx_t REG_BEEP_MEDIUM  = 3'd6;
  localparam cfg_idx_t REG_BEEP_LONG    = 3'd7;

  // Register reset values
  localparam logic [14:0] RST_CRASH_LIMIT  = 15'd12000;
  localparam logic [15:0] RST_LINK_TIMEOUT = 16'd2000;
  localparam logic [7:0]  RST_SLOW_LEVEL   = 8'd80;
  localparam logic [7:0]  RST_MEDIUM_LEVEL = 8'd160;
  localparam logic [7:0]  RST_FAST_LEVEL   = 8'd220;
  localparam logic [15:0] RST_BEEP_SHORT   = 16'd150;
  localparam logic [15:0] RST_BEEP_MEDIUM  = 16'd400;
  localparam logic [15:0] RST_BEEP_LONG    = 16'd900;

  localparam logic [9:0]  IR_RIGHT_LIMIT = 10'd512;
  localparam logic [15:0] AGE_MAX        = 16'hFFFF;

  // Request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

  // Leader heading codes (8-bit two's complement)
  localparam logic [7:0] LEADER_LEFT  = 8'hFF;
  localparam logic [7:0] LEADER_RIGHT = 8'h01;

  // Leader zone codes
  localparam logic [7:0] ZONE_MEDIUM = 8'd1;
  localparam logic [7:0] ZONE_SLOW   = 8'd2;
  localparam logic [7:0] ZONE_STOP   = 8'd3;

  // Own heading codes
  typedef logic signed [1:0] heading_t;
  localparam heading_t HEAD_STRAIGHT = 2'sb00;
  localparam heading_t HEAD_RIGHT    = 2'sb01;
  localparam heading_t HEAD_LEFT     = 2'sb11;

  typedef enum logic [2:0] {
    ALERT_NONE         = 3'd0,
    ALERT_OWN_CRASH    = 3'd1,
    ALERT_BLOCKED      = 3'd2,
    ALERT_LEADER_EMERG = 3'd3,
    ALERT_LEADER_BRAKE = 3'd4
  } alert_t;

endpackage
`default_nettype wire

// ===== sv/fdd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Follower drive decision input channel
// Valid/ready channel carrying one tick or leader packet per transaction.
// ----------------------------------------------------------------------------
interface fdd_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [9:0]        elapsed_ms;
  logic              ir_left_blocked;
  logic [9:0]        ir_right_level;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic              pkt_emergency;
  logic              pkt_crash;
  logic              pkt_braking;
  logic signed [7:0] pkt_direction;
  logic [7:0]        pkt_speed;
  logic [7:0]        pkt_zone;

  modport source (
    output valid, req_type, elapsed_ms, ir_left_blocked, ir_right_level,
           accel_x, accel_y, pkt_emergency, pkt_crash, pkt_braking,
           pkt_direction, pkt_speed, pkt_zone,
    input  ready
  );

  modport sink (
    input  valid, req_type, elapsed_ms, ir_left_blocked, ir_right_level,
           accel_x, accel_y, pkt_emergency, pkt_crash, pkt_braking,
           pkt_direction, pkt_speed, pkt_zone,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/fdd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Follower drive decision result channel
// Valid/ready channel carrying one drive decision per transaction.
// ----------------------------------------------------------------------------
interface fdd_out_if;
  logic              valid;
  logic              ready;
  logic              motors_forward;
  logic [7:0]        left_drive;
  logic [7:0]        right_drive;
  logic signed [1:0] heading;
  logic              brake_flag;
  logic              emergency_flag;
  logic              buzzer_on;
  logic [2:0]        alert_code;
  logic              link_up;
  logic              crash_seen;
  logic              obstacle_left;
  logic              obstacle_right;

  modport source (
    output valid, motors_forward, left_drive, right_drive, heading, brake_flag,
           emergency_flag, buzzer_on, alert_code, link_up, crash_seen,
           obstacle_left, obstacle_right,
    input  ready
  );

  modport sink (
    input  valid, motors_forward, left_drive, right_drive, heading, brake_flag,
           emergency_flag, buzzer_on, alert_code, link_up, crash_seen,
           obstacle_left, obstacle_right,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/follower_drive_decision.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Follower drive decision
// Keeps the leader status, link age and beeper, and turns each control tick
// into a motor drive, buzzer and alert decision by fixed priority.
//
//   channel  direction  handshake         per transaction
//   in_if    in         valid/ready       tick sample or leader packet
//   out_if   out        valid/ready       one decision per tick
//   cfg_*    in         write enable      one register write
//
// Each transaction is settled combinationally: the decision logic sits between
// the stored state and the result register, and a new transaction is taken
// every cycle while the result register is empty or being drained.
// Leader packets update state only and produce no result.
// rst_n is synchronous, active low; it restores register defaults, marks the
// link down and silences the beeper.
// A stalled result holds in the output register and holds off new input.
// ----------------------------------------------------------------------------
module follower_drive_decision (
  input  wire                     clk,
  input  wire                     rst_n,
  fdd_in_if.sink                  in_if,
  fdd_out_if.source               out_if,
  input  wire                     cfg_we,
  input  wire fdd_pkg::cfg_idx_t  cfg_index,
  input  wire fdd_pkg::cfg_data_t cfg_wdata
);
  import fdd_pkg::*;

  // Configuration registers
  logic [14:0] crash_limit_r;
  logic [15:0] link_timeout_r;
  logic [7:0]  slow_level_r, medium_level_r, fast_level_r;
  logic [15:0] beep_short_r, beep_medium_r, beep_long_r;

  // Leader status and timers
  logic        leader_emerg_r, leader_crash_r, leader_brake_r;
  logic [7:0]  leader_heading_r, leader_speed_r, leader_zone_r;
  logic [15:0] link_age_r, link_age_nxt;
  logic        buzz_active_r, buzz_active_nxt;
  logic [15:0] buzz_rem_r, buzz_rem_nxt;

  // Result register
  logic        out_valid_r;
  logic        fwd_r, brake_r, emerg_r, buzz_r, link_r, crash_r, obl_r, obr_r;
  logic [7:0]  ld_r, rd_r;
  heading_t    hd_r;
  alert_t      alert_r;

  // Decision signals
  logic        accept, is_tick;
  logic [16:0] age_sum;
  logic [15:0] rem_dec;
  logic        active_dec;
  logic        link, obl, obr, crash;
  logic [15:0] mag_x, mag_y;
  logic        fwd, brake, emerg, beep_req;
  logic [15:0] beep_len;
  logic [7:0]  ld, rd, zone_speed;
  heading_t    hd;
  alert_t      alert;

  // Take a new transaction when the result register is free or draining
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_tick     = (in_if.req_type == REQ_TICK);

  // Advance link age with saturation and count the beeper down
  assign age_sum    = {1'b0, link_age_r} + {7'd0, in_if.elapsed_ms};
  assign rem_dec    = (buzz_rem_r > {6'd0, in_if.elapsed_ms})
                      ? buzz_rem_r - {6'd0, in_if.elapsed_ms} : 16'd0;
  assign active_dec = buzz_active_r && (rem_dec != 16'd0);

  always_comb begin
    link_age_nxt = age_sum[16] ? AGE_MAX : age_sum[15:0];
  end

  // Sensor conditions; magnitude of 0x8000 wraps to 32768, above any threshold
  assign mag_x = in_if.accel_x[15] ? 16'd0 - in_if.accel_x : in_if.accel_x;
  assign mag_y = in_if.accel_y[15] ? 16'd0 - in_if.accel_y : in_if.accel_y;
  assign crash = (mag_x > {1'b0, crash_limit_r}) ||
                 (mag_y > {1'b0, crash_limit_r});
  assign link  = link_age_nxt < link_timeout_r;
  assign obl   = in_if.ir_left_blocked;
  assign obr   = in_if.ir_right_level < IR_RIGHT_LIMIT;

  always_comb begin
    case (leader_zone_r)
      ZONE_SLOW:   zone_speed = slow_level_r;
      ZONE_MEDIUM: zone_speed = medium_level_r;
      default:     zone_speed = fast_level_r;
    endcase
  end

  // Fixed priority decision
  always_comb begin
    fwd      = 1'b0;
    ld       = 8'd0;
    rd       = 8'd0;
    hd       = HEAD_STRAIGHT;
    brake    = 1'b0;
    emerg    = 1'b0;
    beep_req = 1'b0;
    beep_len = beep_short_r;
    alert    = ALERT_NONE;
    if (crash) begin
      brake = 1'b1; emerg = 1'b1; beep_req = 1'b1; beep_len = beep_long_r;
      alert = ALERT_OWN_CRASH;
    end else if (obl && obr) begin
      brake = 1'b1; beep_req = 1'b1; beep_len = beep_medium_r;
      alert = ALERT_BLOCKED;
    end else if (obl) begin
      // steer right, away from the left obstacle
      fwd = 1'b1; ld = medium_level_r; rd = {1'b0, medium_level_r[7:1]};
      hd = HEAD_RIGHT; beep_req = 1'b1;
    end else if (obr) begin
      fwd = 1'b1; ld = {1'b0, medium_level_r[7:1]}; rd = medium_level_r;
      hd = HEAD_LEFT; beep_req = 1'b1;
    end else if (!link) begin
      brake = 1'b1;
    end else if (leader_emerg_r || leader_crash_r) begin
      brake = 1'b1; emerg = 1'b1; beep_req = 1'b1; beep_len = beep_long_r;
      alert = ALERT_LEADER_EMERG;
    end else if (leader_brake_r) begin
      brake = 1'b1; beep_req = 1'b1; beep_len = beep_medium_r;
      alert = ALERT_LEADER_BRAKE;
    end else if (leader_heading_r == LEADER_LEFT) begin
      fwd = 1'b1; ld = {1'b0, leader_speed_r[7:1]}; rd = leader_speed_r;
      hd = HEAD_LEFT;
    end else if (leader_heading_r == LEADER_RIGHT) begin
      fwd = 1'b1; ld = leader_speed_r; rd = {1'b0, leader_speed_r[7:1]};
      hd = HEAD_RIGHT;
    end else if (leader_zone_r == ZONE_STOP) begin
      brake = 1'b1;
    end else begin
      fwd = 1'b1; ld = zone_speed; rd = zone_speed;
    end
  end

  // A beep starts only when none is still running after the countdown
  always_comb begin
    buzz_active_nxt = active_dec;
    buzz_rem_nxt    = rem_dec;
    if (beep_req && !active_dec) begin
      buzz_active_nxt = 1'b1;
      buzz_rem_nxt    = beep_len;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crash_limit_r  <= RST_CRASH_LIMIT;
      link_timeout_r <= RST_LINK_TIMEOUT;
      slow_level_r   <= RST_SLOW_LEVEL;
      medium_level_r <= RST_MEDIUM_LEVEL;
      fast_level_r   <= RST_FAST_LEVEL;
      beep_short_r   <= RST_BEEP_SHORT;
      beep_medium_r  <= RST_BEEP_MEDIUM;
      beep_long_r    <= RST_BEEP_LONG;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRASH_LIMIT:  crash_limit_r  <= cfg_wdata[14:0];
        REG_LINK_TIMEOUT: link_timeout_r <= cfg_wdata;
        REG_SLOW_LEVEL:   slow_level_r   <= cfg_wdata[7:0];
        REG_MEDIUM_LEVEL: medium_level_r <= cfg_wdata[7:0];
        REG_FAST_LEVEL:   fast_level_r   <= cfg_wdata[7:0];
        REG_BEEP_SHORT:   beep_short_r   <= cfg_wdata;
        REG_BEEP_MEDIUM:  beep_medium_r  <= cfg_wdata;
        REG_BEEP_LONG:    beep_long_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Leader status, link age and beeper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_emerg_r   <= 1'b0;
      leader_crash_r   <= 1'b0;
      leader_brake_r   <= 1'b0;
      leader_heading_r <= 8'd0;
      leader_speed_r   <= 8'd0;
      leader_zone_r    <= 8'd0;
      link_age_r       <= AGE_MAX;
      buzz_active_r    <= 1'b0;
      buzz_rem_r       <= 16'd0;
    end else if (accept) begin
      if (is_tick) begin
        link_age_r    <= link_age_nxt;
        buzz_active_r <= buzz_active_nxt;
        buzz_rem_r    <= buzz_rem_nxt;
      end else begin
        // leader packet: latch status and restart the link age
        leader_emerg_r   <= in_if.pkt_emergency;
        leader_crash_r   <= in_if.pkt_crash;
        leader_brake_r   <= in_if.pkt_braking;
        leader_heading_r <= in_if.pkt_direction;
        leader_speed_r   <= in_if.pkt_speed;
        leader_zone_r    <= in_if.pkt_zone;
        link_age_r       <= 16'd0;
      end
    end
  end

  // Result valid: set by an accepted tick, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      fwd_r   <= fwd;
      ld_r    <= ld;
      rd_r    <= rd;
      hd_r    <= hd;
      brake_r <= brake;
      emerg_r <= emerg;
      buzz_r  <= buzz_active_nxt;
      alert_r <= alert;
      link_r  <= link;
      crash_r <= crash;
      obl_r   <= obl;
      obr_r   <= obr;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.motors_forward = fwd_r;
  assign out_if.left_drive     = ld_r;
  assign out_if.right_drive    = rd_r;
  assign out_if.heading        = hd_r;
  assign out_if.brake_flag     = brake_r;
  assign out_if.emergency_flag = emerg_r;
  assign out_if.buzzer_on      = buzz_r;
  assign out_if.alert_code     = alert_r;
  assign out_if.link_up        = link_r;
  assign out_if.crash_seen     = crash_r;
  assign out_if.obstacle_left  = obl_r;
  assign out_if.obstacle_right = obr_r;

endmodule
`default_nettype wire

// ===== tb/follower_drive_decision_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Follower drive decision testbench
// Drives ticks and leader packets through the valid/ready input channel,
// predicts every drive decision from a local copy of the leader status, link
// age, beeper and registers, and checks each decision field by field. A short
// directed table runs first, then random traffic under several register sets.
// ----------------------------------------------------------------------------
module follower_drive_decision_tb;
  import fdd_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int WATCHDOG_CYCLES = 200000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int NUM_PHASES      = 5;

  // One input transaction, laid out field by field as on the channel
  typedef struct packed {
    logic              req_type;
    logic [9:0]        elapsed_ms;
    logic              ir_left_blocked;
    logic [9:0]        ir_right_level;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic              pkt_emergency;
    logic              pkt_crash;
    logic              pkt_braking;
    logic signed [7:0] pkt_direction;
    logic [7:0]        pkt_speed;
    logic [7:0]        pkt_zone;
  } sample_t;

  // One drive decision, in result channel order
  typedef struct packed {
    logic       motors_forward;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    heading_t   heading;
    logic       brake_flag;
    logic       emergency_flag;
    logic       buzzer_on;
    alert_t     alert_code;
    logic       link_up;
    logic       crash_seen;
    logic       obstacle_left;
    logic       obstacle_right;
  } decision_t;

  // Raw register write data, one word per register
  typedef struct packed {
    logic [15:0] crash_word;
    logic [15:0] link_timeout;
    logic [15:0] slow_word;
    logic [15:0] medium_word;
    logic [15:0] fast_word;
    logic [15:0] beep_short;
    logic [15:0] beep_medium;
    logic [15:0] beep_long;
  } reg_set_t;

  typedef struct {
    sample_t   item;
    bit        typed;
    decision_t want;
  } directed_row_t;

  // Decisions that can be read straight off the priority list
  localparam decision_t LINK_DOWN_STOP = '{1'b0, 8'd0, 8'd0, HEAD_STRAIGHT, 1'b1, 1'b0,
                                           1'b0, ALERT_NONE, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam decision_t OWN_CRASH_STOP = '{1'b0, 8'd0, 8'd0, HEAD_STRAIGHT, 1'b1, 1'b1,
                                           1'b1, ALERT_OWN_CRASH, 1'b0, 1'b1, 1'b0, 1'b0};

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  fdd_in_if  in_if ();
  fdd_out_if out_if ();

  follower_drive_decision dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the registers
  logic [14:0] crash_limit     = RST_CRASH_LIMIT;
  logic [15:0] link_limit      = RST_LINK_TIMEOUT;
  logic [7:0]  slow_level      = RST_SLOW_LEVEL;
  logic [7:0]  medium_level    = RST_MEDIUM_LEVEL;
  logic [7:0]  fast_level      = RST_FAST_LEVEL;
  logic [15:0] short_beep_len  = RST_BEEP_SHORT;
  logic [15:0] medium_beep_len = RST_BEEP_MEDIUM;
  logic [15:0] long_beep_len   = RST_BEEP_LONG;

  // Predictor copy of the block state, at its reset values
  logic        leader_emerg   = 1'b0;
  logic        leader_crashed = 1'b0;
  logic        leader_braking = 1'b0;
  logic [7:0]  leader_dir     = 8'd0;
  logic [7:0]  leader_speed   = 8'd0;
  logic [7:0]  leader_zone    = 8'd0;
  logic [15:0] link_age       = AGE_MAX;
  logic        beeper_on      = 1'b0;
  logic [15:0] beeper_left    = 16'd0;

  decision_t     expected_decisions[$];
  directed_row_t stimulus_table[$];
  reg_set_t      phase_sets[NUM_PHASES];
  int            phase_items[NUM_PHASES] = '{100, 90, 90, 50, 120};
  int            mismatch_count = 0;
  bit            calm = 1'b0;     // no idling on either side when set
  int            stall_left = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] magnitude(input logic signed [15:0] v);
    // -32768 maps to 32768, which still fits in 16 unsigned bits
    return v[15] ? 16'(~v + 16'd1) : 16'(v);
  endfunction

  // A beep only starts when the beeper is silent
  function automatic void start_beep(input logic [15:0] len);
    if (!beeper_on) begin
      beeper_on   = 1'b1;
      beeper_left = len;
    end
  endfunction

  // Advance the predicted state by one transaction; return 1 when it yields
  // a decision, which is left in d.
  function automatic bit decide(input sample_t s, output decision_t d);
    logic [16:0] age_sum;
    logic        link;
    logic        crash;
    logic        obl;
    logic        obr;
    logic [7:0]  zone_level;
    d = '0;
    d.heading    = HEAD_STRAIGHT;
    d.alert_code = ALERT_NONE;
    if (s.req_type == REQ_PACKET) begin
      // Latch the leader status and restart the link age
      leader_emerg   = s.pkt_emergency;
      leader_crashed = s.pkt_crash;
      leader_braking = s.pkt_braking;
      leader_dir     = s.pkt_direction;
      leader_speed   = s.pkt_speed;
      leader_zone    = s.pkt_zone;
      link_age       = 16'd0;
      return 1'b0;
    end

    // Age the link (saturating) and count the beeper down before deciding
    age_sum  = {1'b0, link_age} + s.elapsed_ms;
    link_age = (age_sum > {1'b0, AGE_MAX}) ? AGE_MAX : age_sum[15:0];
    beeper_left = (beeper_left > s.elapsed_ms) ? beeper_left - s.elapsed_ms : 16'd0;
    if (beeper_on && beeper_left == 16'd0) beeper_on = 1'b0;

    link  = link_age < link_limit;
    obl   = s.ir_left_blocked;
    obr   = s.ir_right_level < IR_RIGHT_LIMIT;
    crash = magnitude(s.accel_x) > crash_limit || magnitude(s.accel_y) > crash_limit;

    if (crash) begin
      d.brake_flag     = 1'b1;
      d.emergency_flag = 1'b1;
      d.alert_code     = ALERT_OWN_CRASH;
      start_beep(long_beep_len);
    end else if (obl && obr) begin
      d.brake_flag = 1'b1;
      d.alert_code = ALERT_BLOCKED;
      start_beep(medium_beep_len);
    end else if (obl) begin
      // Steer away from the left obstacle: right side is the inner one
      d.motors_forward = 1'b1;
      d.left_drive     = medium_level;
      d.right_drive    = medium_level >> 1;
      d.heading        = HEAD_RIGHT;
      start_beep(short_beep_len);
    end else if (obr) begin
      d.motors_forward = 1'b1;
      d.left_drive     = medium_level >> 1;
      d.right_drive    = medium_level;
      d.heading        = HEAD_LEFT;
      start_beep(short_beep_len);
    end else if (!link) begin
      d.brake_flag = 1'b1;
    end else if (leader_emerg || leader_crashed) begin
      d.brake_flag     = 1'b1;
      d.emergency_flag = 1'b1;
      d.alert_code     = ALERT_LEADER_EMERG;
      start_beep(long_beep_len);
    end else if (leader_braking) begin
      d.brake_flag = 1'b1;
      d.alert_code = ALERT_LEADER_BRAKE;
      start_beep(medium_beep_len);
    end else if (leader_dir == LEADER_LEFT) begin
      d.motors_forward = 1'b1;
      d.left_drive     = leader_speed >> 1;
      d.right_drive    = leader_speed;
      d.heading        = HEAD_LEFT;
    end else if (leader_dir == LEADER_RIGHT) begin
      d.motors_forward = 1'b1;
      d.left_drive     = leader_speed;
      d.right_drive    = leader_speed >> 1;
      d.heading        = HEAD_RIGHT;
    end else if (leader_zone == ZONE_STOP) begin
      d.brake_flag = 1'b1;
    end else begin
      case (leader_zone)
        ZONE_SLOW:   zone_level = slow_level;
        ZONE_MEDIUM: zone_level = medium_level;
        default:     zone_level = fast_level;
      endcase
      d.motors_forward = 1'b1;
      d.left_drive     = zone_level;
      d.right_drive    = zone_level;
    end

    d.buzzer_on      = beeper_on;
    d.link_up        = link;
    d.crash_seen     = crash;
    d.obstacle_left  = obl;
    d.obstacle_right = obr;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t make_tick(input logic [9:0] elapsed, input logic left,
                                        input logic [9:0] right_level,
                                        input logic signed [15:0] ax,
                                        input logic signed [15:0] ay);
    sample_t s;
    s = '0;
    s.req_type        = REQ_TICK;
    s.elapsed_ms      = elapsed;
    s.ir_left_blocked = left;
    s.ir_right_level  = right_level;
    s.accel_x         = ax;
    s.accel_y         = ay;
    return s;
  endfunction

  function automatic sample_t make_packet(input logic emerg, input logic crashed,
                                          input logic braking,
                                          input logic signed [7:0] dir,
                                          input logic [7:0] speed, input logic [7:0] zone);
    sample_t s;
    s = '0;
    s.req_type      = REQ_PACKET;
    s.pkt_emergency = emerg;
    s.pkt_crash     = crashed;
    s.pkt_braking   = braking;
    s.pkt_direction = dir;
    s.pkt_speed     = speed;
    s.pkt_zone      = zone;
    return s;
  endfunction

  // Mostly well-formed traffic: clean ticks a few tens of ms apart so the link
  // stays up and the leader-driven branches are reached; unused fields carry
  // noise, and now and then a field runs over its whole range.
  function automatic sample_t random_item();
    logic [95:0] noise;
    sample_t     s;
    noise = {$urandom, $urandom, $urandom};
    s = noise[$bits(sample_t)-1:0];
    if ($urandom_range(0, 99) < 25) begin
      s.req_type      = REQ_PACKET;
      s.pkt_emergency = ($urandom_range(0, 11) == 0);
      s.pkt_crash     = ($urandom_range(0, 11) == 0);
      s.pkt_braking   = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 2))
        0:       s.pkt_direction = LEADER_LEFT;
        1:       s.pkt_direction = LEADER_RIGHT;
        default: ;  // keep the random heading, almost always forward
      endcase
      if ($urandom_range(0, 4) != 0) s.pkt_zone = 8'($urandom_range(0, 3));
    end else begin
      s.req_type = REQ_TICK;
      case ($urandom_range(0, 9))
        0:       s.elapsed_ms = 10'd0;
        1:       ;  // keep the full-range elapsed time
        default: s.elapsed_ms = 10'($urandom_range(1, 150));
      endcase
      s.ir_left_blocked = ($urandom_range(0, 7) == 0);
      s.ir_right_level  = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 511))
                                                      : 10'($urandom_range(512, 1023));
      if ($urandom_range(0, 9) != 0) begin
        s.accel_x = 16'(int'($urandom_range(0, 8000)) - 4000);
        s.accel_y = 16'(int'($urandom_range(0, 8000)) - 4000);
      end
    end
    return s;
  endfunction

  // Offer one transaction, wait for it to be taken, then predict its decision.
  // A typed row replaces the prediction with the value written in the table.
  task automatic send_item(input sample_t s, input bit typed, input decision_t want);
    decision_t d;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.req_type        <= s.req_type;
    in_if.elapsed_ms      <= s.elapsed_ms;
    in_if.ir_left_blocked <= s.ir_left_blocked;
    in_if.ir_right_level  <= s.ir_right_level;
    in_if.accel_x         <= s.accel_x;
    in_if.accel_y         <= s.accel_y;
    in_if.pkt_emergency   <= s.pkt_emergency;
    in_if.pkt_crash       <= s.pkt_crash;
    in_if.pkt_braking     <= s.pkt_braking;
    in_if.pkt_direction   <= s.pkt_direction;
    in_if.pkt_speed       <= s.pkt_speed;
    in_if.pkt_zone        <= s.pkt_zone;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (decide(s, d)) expected_decisions.push_back(typed ? want : d);
  endtask

  // Hold the sender until every decision is back, then let a packet that
  // may still be in flight settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_registers(input reg_set_t r);
    write_reg(REG_CRASH_LIMIT,  r.crash_word);
    write_reg(REG_LINK_TIMEOUT, r.link_timeout);
    write_reg(REG_SLOW_LEVEL,   r.slow_word);
    write_reg(REG_MEDIUM_LEVEL, r.medium_word);
    write_reg(REG_FAST_LEVEL,   r.fast_word);
    write_reg(REG_BEEP_SHORT,   r.beep_short);
    write_reg(REG_BEEP_MEDIUM,  r.beep_medium);
    write_reg(REG_BEEP_LONG,    r.beep_long);
    cfg_we <= 1'b0;
    // The block keeps only the low bits of the threshold and level writes
    crash_limit     = r.crash_word[14:0];
    link_limit      = r.link_timeout;
    slow_level      = r.slow_word[7:0];
    medium_level    = r.medium_word[7:0];
    fast_level      = r.fast_word[7:0];
    short_beep_len  = r.beep_short;
    medium_beep_len = r.beep_medium;
    long_beep_len   = r.beep_long;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, then field-by-field comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_decisions.size() == 0) begin
        $error("decision transaction with no tick outstanding");
        mismatch_count++;
      end else begin
        want = expected_decisions.pop_front();
        compare_field("motors_forward", want.motors_forward, out_if.motors_forward);
        compare_field("left_drive",     want.left_drive,     out_if.left_drive);
        compare_field("right_drive",    want.right_drive,    out_if.right_drive);
        compare_field("heading",        want.heading,        out_if.heading);
        compare_field("brake_flag",     want.brake_flag,     out_if.brake_flag);
        compare_field("emergency_flag", want.emergency_flag, out_if.emergency_flag);
        compare_field("buzzer_on",      want.buzzer_on,      out_if.buzzer_on);
        compare_field("alert_code",     want.alert_code,     out_if.alert_code);
        compare_field("link_up",        want.link_up,        out_if.link_up);
        compare_field("crash_seen",     want.crash_seen,     out_if.crash_seen);
        compare_field("obstacle_left",  want.obstacle_left,  out_if.obstacle_left);
        compare_field("obstacle_right", want.obstacle_right, out_if.obstacle_right);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Park every input at a known value before the first edge
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_CRASH_LIMIT;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.req_type        = REQ_TICK;
    in_if.elapsed_ms      = '0;
    in_if.ir_left_blocked = 1'b0;
    in_if.ir_right_level  = '0;
    in_if.accel_x         = '0;
    in_if.accel_y         = '0;
    in_if.pkt_emergency   = 1'b0;
    in_if.pkt_crash       = 1'b0;
    in_if.pkt_braking     = 1'b0;
    in_if.pkt_direction   = '0;
    in_if.pkt_speed       = '0;
    in_if.pkt_zone        = '0;
    out_if.ready          = 1'b0;

    // Directed table, run under the reset register values. The first rows
    // start from a down link and a silent beeper, so their decisions are fixed.
    stimulus_table.push_back('{make_tick(0, 0, 1023, 0, 0), 1'b1, LINK_DOWN_STOP});
    stimulus_table.push_back('{make_tick(0, 0, 1023, -32768, 0), 1'b1, OWN_CRASH_STOP});
    // Beeper runs out on this tick and the new crash restarts it
    stimulus_table.push_back('{make_tick(1023, 0, 1023, 0, 32767), 1'b1, OWN_CRASH_STOP});
    // Magnitude equal to the threshold is no crash; both sides blocked
    stimulus_table.push_back('{make_tick(1023, 1, 0, 12000, -12000), 1'b0, '0});
    stimulus_table.push_back('{make_tick(10, 1, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(10, 0, 511, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(10, 0, 512, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(1, 0, 0, 0, 255, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(0, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 1, 0, 0, 255, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 1, 0, 255, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, -1, 255, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, 1, 255, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, -128, 0, ZONE_STOP), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, 127, 0, ZONE_SLOW), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, 0, 0, ZONE_MEDIUM), 1'b0, '0});
    stimulus_table.push_back('{make_tick(5, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_packet(0, 0, 0, 0, 7, 255), 1'b0, '0});
    // Two long ticks carry the link age past the timeout
    stimulus_table.push_back('{make_tick(1023, 0, 1023, 0, 0), 1'b0, '0});
    stimulus_table.push_back('{make_tick(1023, 0, 1023, 0, 0), 1'b0, '0});

    // Register sets for the random phases: moderate, all low, all high
    // (threshold written with its unused top bit set), zero timeout, moderate
    phase_sets[0] = '{16'($urandom_range(2000, 20000)), 16'($urandom_range(300, 3000)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 1500)),
                      16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500))};
    phase_sets[1] = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    phase_sets[2] = '{16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255,
                      16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_sets[3] = '{16'd12000, 16'd0, 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                      16'($urandom_range(0, 400))};
    phase_sets[4] = '{16'($urandom_range(2000, 20000)), 16'($urandom_range(300, 3000)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 1500)),
                      16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500))};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stimulus_table[i])
      send_item(stimulus_table[i].item, stimulus_table[i].typed, stimulus_table[i].want);

    // Random phases; the sender waits out every decision before each
    // register change, and the last phase runs without any idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      load_registers(phase_sets[p]);
      calm = (p == NUM_PHASES - 1);
      repeat (phase_items[p]) send_item(random_item(), 1'b0, '0);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fdd_pkg.sv
sv/fdd_in_if.sv
sv/fdd_out_if.sv
sv/follower_drive_decision.sv
tb/follower_drive_decision_tb.sv
